@@ rtl/core/qts_pkg.sv @@
// Shared types, constants and a helper function for the quoted token splitter.
package qts_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CAP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_SPACE  = 2'd0;
	localparam logic [1:0] MODE_SEP    = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_EOT  = 2'd1,
		KIND_EOS  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PLAIN = 2'd1,
		PH_QUOTE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		CFG_SPLIT_MODE  = 3'd0,
		CFG_SEPARATOR   = 3'd1,
		CFG_QUOTE_COUNT = 3'd2,
		CFG_QUOTE_A     = 3'd3,
		CFG_QUOTE_B     = 3'd4,
		CFG_QUOTE_C     = 3'd5,
		CFG_QUOTE_D     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] split_mode;
		logic [7:0] separator_byte;
		logic [2:0] quote_count;
		logic [7:0] quote_byte_a;
		logic [7:0] quote_byte_b;
		logic [7:0] quote_byte_c;
		logic [7:0] quote_byte_d;
	} cfg_t;

	typedef struct packed {
		phase_t                  phase;
		logic [7:0]              open_quote;
		logic [COUNT_BITS-1:0]   tally;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  token_byte;
		logic [15:0] token_total;
		logic        last_of_run;
	} result_t;

	function automatic logic [15:0] cap_total(input logic [COUNT_BITS-1:0] t);
		logic [CAP_W-1:0] w;
		w = CAP_W'(t);
		if (w > CAP_W'(16'hFFFF))
			return 16'hFFFF;
		return w[15:0];
	endfunction

endpackage

@@ rtl/core/qts_in_if.sv @@
// Input channel carrying one string byte or the end marker per item.
interface qts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_marker;

	modport source (output valid, output char_code, output end_marker, input ready);
	modport sink (input valid, input char_code, input end_marker, output ready);
endinterface

@@ rtl/core/qts_out_if.sv @@
// Output channel carrying one token result item.
interface qts_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [7:0]  token_byte;
	logic [15:0] token_total;
	logic        last_of_run;

	modport source (output valid, output item_kind, output token_byte, output token_total,
		output last_of_run, input ready);
	modport sink (input valid, input item_kind, input token_byte, input token_total,
		input last_of_run, output ready);
endinterface

@@ rtl/core/qts_cfg_if.sv @@
// Configuration write channel carrying a register index and write data.
interface qts_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/qts_cfg.sv @@
// Configuration register file for the quoted token splitter.
module qts_cfg (
	input  logic          clk,
	input  logic          arst_n,
	qts_cfg_if.sink       cfg,
	output qts_pkg::cfg_t regs
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.split_mode     <= qts_pkg::MODE_SPACE;
			regs.separator_byte <= 8'd44;
			regs.quote_count    <= 3'd0;
			regs.quote_byte_a   <= 8'd34;
			regs.quote_byte_b   <= 8'd39;
			regs.quote_byte_c   <= 8'd34;
			regs.quote_byte_d   <= 8'd34;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				qts_pkg::CFG_SPLIT_MODE:  regs.split_mode     <= cfg.data[1:0];
				qts_pkg::CFG_SEPARATOR:   regs.separator_byte <= cfg.data;
				qts_pkg::CFG_QUOTE_COUNT: regs.quote_count    <= cfg.data[2:0];
				qts_pkg::CFG_QUOTE_A:     regs.quote_byte_a   <= cfg.data;
				qts_pkg::CFG_QUOTE_B:     regs.quote_byte_b   <= cfg.data;
				qts_pkg::CFG_QUOTE_C:     regs.quote_byte_c   <= cfg.data;
				qts_pkg::CFG_QUOTE_D:     regs.quote_byte_d   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/qts_scan.sv @@
// Per-byte scan logic: classifies one item and forms its results and next state.
module qts_scan (
	input  qts_pkg::cfg_t    cfg,
	input  qts_pkg::state_t  st,
	input  logic [7:0]       char_code,
	input  logic             end_marker,
	output qts_pkg::state_t  st_next,
	output logic [1:0]       n_res,
	output qts_pkg::result_t res0,
	output qts_pkg::result_t res1
);

	logic [qts_pkg::COUNT_BITS-1:0] tally_inc;
	logic                           is_space;
	logic                           is_quote;
	logic                           is_delim;
	qts_pkg::state_t                st_ended;
	qts_pkg::result_t               r_byte;
	qts_pkg::result_t               r_eot;

	assign tally_inc = (st.tally == '1) ? st.tally
		: st.tally + qts_pkg::COUNT_BITS'(1);

	assign is_space = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);

	assign is_quote = (cfg.quote_count >= 3'd1 && char_code == cfg.quote_byte_a)
		|| (cfg.quote_count >= 3'd2 && char_code == cfg.quote_byte_b)
		|| (cfg.quote_count >= 3'd3 && char_code == cfg.quote_byte_c)
		|| (cfg.quote_count >= 3'd4 && char_code == cfg.quote_byte_d);

	assign is_delim = (cfg.split_mode == qts_pkg::MODE_SEP)
		? (char_code == cfg.separator_byte) : is_space;

	assign st_ended = '{phase: qts_pkg::PH_IDLE, open_quote: 8'd0, tally: tally_inc};
	assign r_byte = '{kind: qts_pkg::KIND_BYTE, token_byte: char_code,
		token_total: qts_pkg::cap_total(st.tally), last_of_run: 1'b1};
	assign r_eot = '{kind: qts_pkg::KIND_EOT, token_byte: 8'd0,
		token_total: qts_pkg::cap_total(tally_inc), last_of_run: 1'b1};

	always_comb begin
		st_next = st;
		n_res   = 2'd0;
		res0    = r_byte;
		res1    = '{kind: qts_pkg::KIND_EOS, token_byte: 8'd0,
			token_total: qts_pkg::cap_total(tally_inc), last_of_run: 1'b1};
		if (end_marker) begin
			st_next = '{phase: qts_pkg::PH_IDLE, open_quote: 8'd0, tally: '0};
			if (st.phase != qts_pkg::PH_IDLE) begin
				n_res = 2'd2;
				res0  = r_eot;
				res0.last_of_run = 1'b0;
			end else begin
				n_res = 2'd1;
				res0  = '{kind: qts_pkg::KIND_EOS, token_byte: 8'd0,
					token_total: qts_pkg::cap_total(st.tally), last_of_run: 1'b1};
			end
		end else if (cfg.split_mode == qts_pkg::MODE_QUOTED) begin
			if (st.phase == qts_pkg::PH_QUOTE) begin
				n_res = 2'd1;
				if (char_code == st.open_quote) begin
					res0    = r_eot;
					st_next = st_ended;
				end
			end else if (is_quote) begin
				st_next.phase      = qts_pkg::PH_QUOTE;
				st_next.open_quote = char_code;
			end else if (is_space) begin
				if (st.phase != qts_pkg::PH_IDLE) begin
					n_res   = 2'd1;
					res0    = r_eot;
					st_next = st_ended;
				end
			end else begin
				n_res         = 2'd1;
				st_next.phase = qts_pkg::PH_PLAIN;
			end
		end else begin
			if (is_delim) begin
				if (st.phase != qts_pkg::PH_IDLE) begin
					n_res   = 2'd1;
					res0    = r_eot;
					st_next = st_ended;
				end
			end else begin
				n_res              = 2'd1;
				st_next.phase      = qts_pkg::PH_PLAIN;
				st_next.open_quote = 8'd0;
			end
		end
	end

endmodule

@@ rtl/core/qts_rbuf.sv @@
// Small result queue that takes up to two items per cycle and sends one when the sink is ready.
module qts_rbuf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_n,
	input  qts_pkg::result_t           push0,
	input  qts_pkg::result_t           push1,
	output logic [qts_pkg::QCNT_W-1:0] free_slots,
	qts_out_if.source                  res
);

	qts_pkg::result_t                mem_q [qts_pkg::QDEPTH];
	logic [qts_pkg::QPTR_W-1:0]      head_q;
	logic [qts_pkg::QPTR_W-1:0]      tail_q;
	logic [qts_pkg::QCNT_W-1:0]      count_q;
	logic                            pop;
	logic [qts_pkg::QPTR_W-1:0]      tail_p1;
	qts_pkg::result_t                head_item;

	assign pop        = res.valid && res.ready;
	assign tail_p1    = tail_q + qts_pkg::QPTR_W'(1);
	assign free_slots = qts_pkg::QCNT_W'(qts_pkg::QDEPTH) - count_q
		+ qts_pkg::QCNT_W'(pop);

	assign head_item       = mem_q[head_q];
	assign res.valid       = (count_q != '0);
	assign res.item_kind   = head_item.kind;
	assign res.token_byte  = head_item.token_byte;
	assign res.token_total = head_item.token_total;
	assign res.last_of_run = head_item.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + qts_pkg::QPTR_W'(pop);
			tail_q  <= tail_q + qts_pkg::QPTR_W'(push_n);
			count_q <= count_q + qts_pkg::QCNT_W'(push_n) - qts_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[tail_q] <= push0;
		if (push_n == 2'd2)
			mem_q[tail_p1] <= push1;
	end

endmodule

@@ rtl/core/quoted_token_splitter_unit.sv @@
// Top level of the quoted token splitter.
// An accepted item is registered, then its results are written to the queue that offers them.
// Throughput: one input item per cycle; an end item that closes a token makes two results,
// and the input stalls only when the four-entry result queue has no room for the results.
// Reset: arst_n clears the scan state, the queue and the configuration to its defaults.
module quoted_token_splitter_unit (
	input  logic      clk,
	input  logic      arst_n,
	qts_in_if.sink    chars,
	qts_out_if.source tokens,
	qts_cfg_if.sink   cfg
);

	qts_pkg::cfg_t                regs;
	qts_pkg::state_t              st_q;
	qts_pkg::state_t              st_next;
	qts_pkg::result_t             res0;
	qts_pkg::result_t             res1;
	logic [1:0]                   n_res;
	logic [qts_pkg::QCNT_W-1:0]   free_slots;
	logic                         valid_s1;
	logic [7:0]                   char_s1;
	logic                         end_s1;
	logic                         fire;

	qts_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	qts_scan u_scan (
		.cfg        (regs),
		.st         (st_q),
		.char_code  (char_s1),
		.end_marker (end_s1),
		.st_next    (st_next),
		.n_res      (n_res),
		.res0       (res0),
		.res1       (res1)
	);

	qts_rbuf u_rbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (fire ? n_res : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.free_slots (free_slots),
		.res        (tokens)
	);

	assign fire        = valid_s1 && (qts_pkg::QCNT_W'(n_res) <= free_slots);
	assign chars.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{phase: qts_pkg::PH_IDLE, open_quote: 8'd0, tally: '0};
		end else begin
			if (chars.valid && chars.ready)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			end_s1  <= chars.end_marker;
		end
	end

`ifndef SYNTH
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_slots <= qts_pkg::QCNT_W'(qts_pkg::QDEPTH))
		else $error("Result queue reports more free slots than it has.");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_s1) |=> (st_q.phase == qts_pkg::PH_IDLE && st_q.tally == '0))
		else $error("Scan state not cleared after the end of a string.");

	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n_res == 2'd2) |-> end_s1)
		else $error("Two results made by an item that does not end the string.");
`endif

endmodule
